FILE: rtl/trcc_pkg.sv
// Shared types, constants and character mapping functions for the two-rotor character cipher.
package trcc_pkg;

	localparam int ROTOR_ENTRIES = 28;
	localparam int IDX_W         = 5;
	localparam int CHAR_W        = 8;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_CODE   = 2'd2;

	localparam logic [IDX_W-1:0] IDX_SPACE  = IDX_W'(26);
	localparam logic [IDX_W-1:0] IDX_PERIOD = IDX_W'(27);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(ROTOR_ENTRIES - 1);
	localparam logic [IDX_W:0]   ENTRIES_W  = (IDX_W+1)'(ROTOR_ENTRIES);

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_PERIOD   = 8'd46;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'd65;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'd90;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'd97;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'd122;
	localparam logic [CHAR_W-1:0] CODE_NO_MATCH = 8'd93;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [CHAR_W-1:0] entry_value;
		logic [CHAR_W-1:0] char_in;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              bad_char;
		logic              no_match;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_VAL  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic take;
		logic start;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_code;
		logic sym_ok;
		logic match;
		logic last;
		logic slot_free;
	} status_t;

	function automatic logic is_upper(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
	endfunction

	function automatic logic is_lower(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
	endfunction

	function automatic logic sym_ok(input logic [CHAR_W-1:0] c);
		return is_upper(c) || is_lower(c) || (c == CHAR_SPACE) || (c == CHAR_PERIOD);
	endfunction

	function automatic logic [IDX_W-1:0] sym_index(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = '0;
		if (is_lower(c)) begin
			d = c - CHAR_LOWER_A;
		end else if (is_upper(c)) begin
			d = c - CHAR_UPPER_A;
		end else if (c == CHAR_SPACE) begin
			d = CHAR_W'(IDX_SPACE);
		end else begin
			d = CHAR_W'(IDX_PERIOD);
		end
		return d[IDX_W-1:0];
	endfunction

	function automatic logic [CHAR_W-1:0] sym_char(input logic [IDX_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		if (idx == IDX_SPACE) begin
			c = CHAR_SPACE;
		end else if (idx == IDX_PERIOD) begin
			c = CHAR_PERIOD;
		end else begin
			c = CHAR_W'(idx) + CHAR_UPPER_A;
		end
		return c;
	endfunction

	// (i + p) mod ROTOR_ENTRIES for i, p below ROTOR_ENTRIES.
	function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] i,
			input logic [IDX_W-1:0] p);
		logic [IDX_W:0] s;
		s = {1'b0, i} + {1'b0, p};
		if (s >= ENTRIES_W) begin
			s = s - ENTRIES_W;
		end
		return s[IDX_W-1:0];
	endfunction

	// (i - p) mod ROTOR_ENTRIES for i, p below ROTOR_ENTRIES.
	function automatic logic [IDX_W-1:0] sub_mod(input logic [IDX_W-1:0] i,
			input logic [IDX_W-1:0] p);
		logic [IDX_W:0] s;
		s = {1'b0, i} + ENTRIES_W - {1'b0, p};
		if (s >= ENTRIES_W) begin
			s = s - ENTRIES_W;
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/trcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 28
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/trcc_dp.sv
// Datapath of the two-rotor character cipher: rotor memories, position, scan and result.
module trcc_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	input  trcc_pkg::req_t  req_data,
	input  logic            rsp_stall,
	output logic            rsp_valid,
	output trcc_pkg::rsp_t  rsp_data,
	input  trcc_pkg::cmd_t  cmd,
	output trcc_pkg::status_t status
);

	logic                          mode_q;
	logic [trcc_pkg::IDX_W-1:0]    pos_q;
	logic [trcc_pkg::IDX_W-1:0]    idx_q;
	logic [trcc_pkg::IDX_W-1:0]    cnt_q;
	trcc_pkg::rsp_t                res_q;
	trcc_pkg::rsp_t                out_q;
	logic                          out_valid_q;

	logic                          is_load;
	logic                          in_range;
	logic                          we_a;
	logic                          we_b;
	logic [trcc_pkg::IDX_W-1:0]    scan_j;
	logic [trcc_pkg::IDX_W-1:0]    val_addr;
	logic [trcc_pkg::IDX_W-1:0]    scan_addr;
	logic [trcc_pkg::IDX_W-1:0]    raddr_a;
	logic [trcc_pkg::IDX_W-1:0]    raddr_b;
	logic [trcc_pkg::CHAR_W-1:0]   rdata_a;
	logic [trcc_pkg::CHAR_W-1:0]   rdata_b;
	logic                          match;
	logic                          last;

	assign is_load  = (req_data.opcode == trcc_pkg::OP_LOAD_A) ||
		(req_data.opcode == trcc_pkg::OP_LOAD_B);
	assign in_range = req_data.entry_index <= trcc_pkg::IDX_LAST;
	assign we_a     = cmd.take && in_range && (req_data.opcode == trcc_pkg::OP_LOAD_A);
	assign we_b     = cmd.take && in_range && (req_data.opcode == trcc_pkg::OP_LOAD_B);

	assign scan_j    = (cmd.start || last) ? '0 : cnt_q + 1'b1;
	assign val_addr  = mode_q ? trcc_pkg::add_mod(idx_q, pos_q)
		: trcc_pkg::sub_mod(idx_q, pos_q);
	assign scan_addr = mode_q ? trcc_pkg::sub_mod(scan_j, pos_q)
		: trcc_pkg::add_mod(scan_j, pos_q);
	assign raddr_a   = mode_q ? scan_addr : val_addr;
	assign raddr_b   = mode_q ? val_addr : scan_addr;

	assign match = rdata_a == rdata_b;
	assign last  = cnt_q == trcc_pkg::IDX_LAST;

	trcc_ram #(
		.WIDTH (trcc_pkg::CHAR_W),
		.DEPTH (trcc_pkg::ROTOR_ENTRIES)
	) u_rotor_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (req_data.entry_index),
		.wdata (req_data.entry_value),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	trcc_ram #(
		.WIDTH (trcc_pkg::CHAR_W),
		.DEPTH (trcc_pkg::ROTOR_ENTRIES)
	) u_rotor_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (req_data.entry_index),
		.wdata (req_data.entry_value),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.take && is_load) begin
				pos_q <= '0;
			end else if (cmd.step && (match || last)) begin
				pos_q <= (pos_q == trcc_pkg::IDX_LAST) ? '0 : pos_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q          <= trcc_pkg::sym_index(req_data.char_in);
			res_q.char_out <= req_data.char_in;
			res_q.bad_char <= req_data.char_in != trcc_pkg::CHAR_NEWLINE;
			res_q.no_match <= 1'b0;
		end
		if (cmd.start) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			if (match) begin
				res_q.char_out <= trcc_pkg::sym_char(cnt_q);
				res_q.bad_char <= 1'b0;
				res_q.no_match <= 1'b0;
			end else if (last) begin
				res_q.char_out <= trcc_pkg::CODE_NO_MATCH;
				res_q.bad_char <= 1'b0;
				res_q.no_match <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	assign status.is_code   = req_data.opcode == trcc_pkg::OP_CODE;
	assign status.sym_ok    = trcc_pkg::sym_ok(req_data.char_in);
	assign status.match     = match;
	assign status.last      = last;
	assign status.slot_free = !out_valid_q || !rsp_stall;

endmodule

FILE: rtl/trcc_ctrl.sv
// Controller state machine of the two-rotor character cipher.
module trcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  trcc_pkg::status_t status,
	output trcc_pkg::cmd_t    cmd
);

	trcc_pkg::state_t state_q;
	trcc_pkg::state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			trcc_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				cmd.take  = req_valid;
				if (req_valid && status.is_code) begin
					state_d = status.sym_ok ? trcc_pkg::ST_VAL : trcc_pkg::ST_EMIT;
				end
			end
			trcc_pkg::ST_VAL: begin
				cmd.start = 1'b1;
				state_d   = trcc_pkg::ST_SCAN;
			end
			trcc_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.match || status.last) begin
					state_d = trcc_pkg::ST_EMIT;
				end
			end
			trcc_pkg::ST_EMIT: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = trcc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = trcc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/two_rotor_char_cipher.sv
// Top level of the two-rotor character cipher: controller, datapath and checks.
//
// Requests arrive on req_valid/req_stall with a req_data payload; a transfer
// takes place at a rising edge where req_valid is high and req_stall is low.
// Opcodes load an entry of rotor A or rotor B, or code one character. Results
// leave on rsp_valid/rsp_stall with rsp_data, one per code request, none for loads.
// decrypt_mode is to be written by the user through cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this. A load clears the
// rotation position. A code request for a letter, space or period is accepted,
// then the rotor value is read, then the other rotor is scanned at one entry a
// cycle up to the first match (at most 28 entries compared), and then the result
// is placed. Newlines and other characters are passed through. The next request
// is taken in the cycle after the result is placed; a result left waiting does
// not hold off further transfers until the next result is ready. While the
// receiver stalls, the result holds and the controller waits before placing a
// new one. Reset clears the mode, the rotation position and the output valid;
// the rotor memories are undefined until loaded.
module two_rotor_char_cipher (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           req_valid,
	output logic           req_stall,
	input  trcc_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output trcc_pkg::rsp_t rsp_data
);

	trcc_pkg::cmd_t    cmd;
	trcc_pkg::status_t status;

	trcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	trcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.status    (status)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.start, cmd.step, cmd.emit}))
		else $error("More than one controller command in a cycle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.slot_free)
		else $error("Result placed over one that has not been transferred.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.no_match |->
			rsp_data.char_out == trcc_pkg::CODE_NO_MATCH && !rsp_data.bad_char)
		else $error("Missing match reported with a wrong character or flag.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> cmd.step)
		else $error("Rotor read not followed by the scan.");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the two-rotor character cipher, with its own cipher predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic req_valid;
	logic req_stall;
	trcc_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	trcc_pkg::rsp_t rsp_data;

	two_rotor_char_cipher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	logic [trcc_pkg::CHAR_W-1:0] rotor_a [trcc_pkg::ROTOR_ENTRIES];
	logic [trcc_pkg::CHAR_W-1:0] rotor_b [trcc_pkg::ROTOR_ENTRIES];
	int   turn;
	logic decrypt_q;
	trcc_pkg::rsp_t pending_codes [$];
	trcc_pkg::rsp_t want;
	int   burst_left;
	int   err_count;
	int   n_results;
	int   n_unmatched;
	int   n_flagged;
	int   n_loads;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("two_rotor_char_cipher: mismatch");
		$finish;
	end

	function automatic logic [trcc_pkg::CHAR_W-1:0] a_at(input int i);
		return rotor_a[5'((i + trcc_pkg::ROTOR_ENTRIES - turn) % trcc_pkg::ROTOR_ENTRIES)];
	endfunction

	function automatic logic [trcc_pkg::CHAR_W-1:0] b_at(input int i);
		return rotor_b[5'((i + turn) % trcc_pkg::ROTOR_ENTRIES)];
	endfunction

	function automatic void cipher_step(input trcc_pkg::req_t r);
		trcc_pkg::rsp_t res;
		int sym;
		int j;
		int hit;
		logic [trcc_pkg::CHAR_W-1:0] key;
		case (r.opcode)
			trcc_pkg::OP_LOAD_A, trcc_pkg::OP_LOAD_B: begin
				if (r.entry_index < trcc_pkg::ROTOR_ENTRIES) begin
					if (r.opcode == trcc_pkg::OP_LOAD_A) begin
						rotor_a[r.entry_index] = r.entry_value;
					end else begin
						rotor_b[r.entry_index] = r.entry_value;
					end
				end
				turn = 0;
				n_loads++;
			end
			trcc_pkg::OP_CODE: begin
				res.char_out = r.char_in;
				res.bad_char = 1'b0;
				res.no_match = 1'b0;
				sym = -1;
				if (r.char_in >= trcc_pkg::CHAR_LOWER_A && r.char_in <= trcc_pkg::CHAR_LOWER_Z) begin
					sym = int'(r.char_in) - int'(trcc_pkg::CHAR_LOWER_A);
				end else if (r.char_in >= trcc_pkg::CHAR_UPPER_A
						&& r.char_in <= trcc_pkg::CHAR_UPPER_Z) begin
					sym = int'(r.char_in) - int'(trcc_pkg::CHAR_UPPER_A);
				end else if (r.char_in == trcc_pkg::CHAR_SPACE) begin
					sym = int'(trcc_pkg::IDX_SPACE);
				end else if (r.char_in == trcc_pkg::CHAR_PERIOD) begin
					sym = int'(trcc_pkg::IDX_PERIOD);
				end
				if (sym < 0) begin
					res.bad_char = (r.char_in != trcc_pkg::CHAR_NEWLINE);
					if (res.bad_char) n_flagged++;
				end else begin
					key = decrypt_q ? b_at(sym) : a_at(sym);
					hit = -1;
					for (j = 0; j < trcc_pkg::ROTOR_ENTRIES && hit < 0; j++) begin
						if ((decrypt_q ? a_at(j) : b_at(j)) == key) hit = j;
					end
					if (hit < 0) begin
						res.char_out = trcc_pkg::CODE_NO_MATCH;
						res.no_match = 1'b1;
						n_unmatched++;
					end else if (hit == int'(trcc_pkg::IDX_SPACE)) begin
						res.char_out = trcc_pkg::CHAR_SPACE;
					end else if (hit == int'(trcc_pkg::IDX_PERIOD)) begin
						res.char_out = trcc_pkg::CHAR_PERIOD;
					end else begin
						res.char_out = trcc_pkg::CHAR_UPPER_A + 8'(hit);
					end
					turn = (turn + 1) % trcc_pkg::ROTOR_ENTRIES;
				end
				n_results++;
				pending_codes.push_back(res);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_codes.size() == 0) begin
					if (err_count < MAX_REPORTS) begin
						$display("Unexpected result: char %02h bad %b nomatch %b",
							rsp_data.char_out, rsp_data.bad_char, rsp_data.no_match);
					end
					err_count++;
				end else begin
					want = pending_codes.pop_front();
					if (rsp_data.char_out !== want.char_out
							|| rsp_data.bad_char !== want.bad_char
							|| rsp_data.no_match !== want.no_match) begin
						if (err_count < MAX_REPORTS) begin
							$display({"Wrong result at %0t: expected char %02h bad %b nomatch %b,",
								" got char %02h bad %b nomatch %b"},
								$realtime, want.char_out, want.bad_char, want.no_match,
								rsp_data.char_out, rsp_data.bad_char, rsp_data.no_match);
						end
						err_count++;
					end
				end
			end
			if (req_valid && !req_stall) cipher_step(req_data);
		end
	end

	initial begin
		int left;
		int style;
		int phase;
		rsp_stall <= 1'b0;
		left = 0;
		style = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			phase++;
			case (style)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 1) == 1);
				2: rsp_stall <= ($urandom_range(0, 9) < 8);
				default: rsp_stall <= ((phase % 7) < 3);
			endcase
		end
	end

	task automatic send_item(input trcc_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic code_char(input logic [trcc_pkg::CHAR_W-1:0] c);
		trcc_pkg::req_t r;
		r.opcode = trcc_pkg::OP_CODE;
		r.entry_index = 5'($urandom_range(0, 31));
		r.entry_value = 8'($urandom_range(0, 255));
		r.char_in = c;
		send_item(r);
	endtask

	task automatic load_entry(input logic [1:0] op, input int idx, input int val);
		trcc_pkg::req_t r;
		r.opcode = op;
		r.entry_index = 5'(idx);
		r.entry_value = 8'(val);
		r.char_in = 8'($urandom_range(0, 255));
		send_item(r);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_codes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_mode(input logic m);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		decrypt_q = m;
	endtask

	task automatic test_passthrough();
		trcc_pkg::req_t r;
		write_mode(1'b0);
		code_char(trcc_pkg::CHAR_NEWLINE);
		code_char(8'd0);
		code_char(8'd255);
		code_char(8'd9);
		code_char(8'd64);
		code_char(8'd91);
		code_char(8'd96);
		code_char(8'd123);
		code_char(8'd127);
		code_char(8'd128);
		code_char(8'd47);
		r.opcode = OP_NOP;
		r.entry_index = 5'd31;
		r.entry_value = 8'd255;
		r.char_in = trcc_pkg::CHAR_UPPER_A;
		send_item(r);
		code_char(trcc_pkg::CHAR_NEWLINE);
	endtask

	task automatic test_rotor_load();
		int i;
		for (i = 0; i < trcc_pkg::ROTOR_ENTRIES; i++) begin
			load_entry(trcc_pkg::OP_LOAD_A, i, (5 * i) % trcc_pkg::ROTOR_ENTRIES);
			load_entry(trcc_pkg::OP_LOAD_B, i, (3 * i + 7) % trcc_pkg::ROTOR_ENTRIES);
		end
		for (i = trcc_pkg::ROTOR_ENTRIES; i < 32; i++) begin
			load_entry(trcc_pkg::OP_LOAD_A, i, 255);
			load_entry(trcc_pkg::OP_LOAD_B, i, 255);
		end
	endtask

	task automatic test_encrypt();
		write_mode(1'b0);
		code_char(trcc_pkg::CHAR_UPPER_A);
		code_char(trcc_pkg::CHAR_UPPER_Z);
		code_char(trcc_pkg::CHAR_LOWER_A);
		code_char(trcc_pkg::CHAR_LOWER_Z);
		code_char(trcc_pkg::CHAR_SPACE);
		code_char(trcc_pkg::CHAR_PERIOD);
		code_char(trcc_pkg::CHAR_NEWLINE);
		code_char(8'd77);
		load_entry(trcc_pkg::OP_LOAD_A, 3, 255);
		code_char(8'd68);
		code_char(8'd69);
		load_entry(trcc_pkg::OP_LOAD_B, 30, 0);
		code_char(8'd100);
		load_entry(trcc_pkg::OP_LOAD_A, 3, 15);
		code_char(8'd68);
	endtask

	task automatic test_decrypt();
		write_mode(1'b1);
		code_char(trcc_pkg::CHAR_UPPER_A);
		code_char(trcc_pkg::CHAR_LOWER_Z);
		code_char(trcc_pkg::CHAR_SPACE);
		code_char(trcc_pkg::CHAR_PERIOD);
		code_char(8'd63);
		load_entry(trcc_pkg::OP_LOAD_B, 5, 255);
		code_char(8'd70);
		code_char(8'd102);
		load_entry(trcc_pkg::OP_LOAD_B, 5, 22);
		code_char(8'd70);
	endtask

	task automatic test_random(input int phases, input int per_phase);
		int ph;
		int i;
		int sent;
		int pick;
		int vmax;
		trcc_pkg::req_t r;
		for (ph = 0; ph < phases; ph++) begin
			write_mode((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
			pick = $urandom_range(0, 2);
			vmax = (pick == 0) ? 27 : (pick == 1) ? 40 : 255;
			if ($urandom_range(0, 2) == 0) begin
				for (i = 0; i < trcc_pkg::ROTOR_ENTRIES; i++) begin
					load_entry(trcc_pkg::OP_LOAD_A, i, $urandom_range(0, vmax));
					load_entry(trcc_pkg::OP_LOAD_B, i, $urandom_range(0, vmax));
				end
			end
			sent = 0;
			while (sent < per_phase) begin
				pick = $urandom_range(0, 99);
				r.entry_index = 5'($urandom_range(0, 31));
				r.entry_value = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, vmax))
					: 8'($urandom_range(0, 255));
				r.char_in = 8'($urandom_range(0, 255));
				if (pick < 6) begin
					r.opcode = trcc_pkg::OP_LOAD_A;
				end else if (pick < 12) begin
					r.opcode = trcc_pkg::OP_LOAD_B;
				end else if (pick < 16) begin
					r.opcode = OP_NOP;
				end else begin
					r.opcode = trcc_pkg::OP_CODE;
					if (pick < 20) begin
						r.char_in = trcc_pkg::CHAR_NEWLINE;
					end else if (pick >= 24) begin
						pick = $urandom_range(0, 9);
						if (pick == 0) begin
							r.char_in = trcc_pkg::CHAR_SPACE;
						end else if (pick == 1) begin
							r.char_in = trcc_pkg::CHAR_PERIOD;
						end else begin
							r.char_in = (($urandom_range(0, 1) == 1) ? trcc_pkg::CHAR_UPPER_A
								: trcc_pkg::CHAR_LOWER_A) + 8'($urandom_range(0, 25));
						end
					end
				end
				send_item(r);
				if (r.opcode != OP_NOP) sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		turn = 0;
		decrypt_q = 1'b0;
		burst_left = 0;
		err_count = 0;
		n_results = 0;
		n_unmatched = 0;
		n_flagged = 0;
		n_loads = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_passthrough();
		test_rotor_load();
		test_encrypt();
		test_decrypt();
		test_random(12, 70);
		wait_idle();
		$display("Run covered %0d rotor loads and %0d coded characters in both modes,",
			n_loads, n_results);
		$display("of which %0d found no match and %0d were flagged as bad.", n_unmatched, n_flagged);
		if (err_count == 0) begin
			$display("two_rotor_char_cipher: match");
		end else begin
			$display("two_rotor_char_cipher: mismatch");
		end
		$finish;
	end

endmodule
